[hdl/pmt_pkg.sv]
// Shared types and constants for the PMT section parser.
package pmt_pkg;

	// Depth of the command queue and of the result queue (power of two).
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [12:0] HDR_FIXED_LEN = 13'd13;
	localparam logic [12:0] ENTRY_FIXED_LEN = 13'd5;

	// Byte roles handed from the classifier to the field assembler.
	typedef enum logic [3:0] {
		OP_START,
		OP_PROG_HI,
		OP_PROG_LO,
		OP_VERSION,
		OP_SECNUM,
		OP_LASTSEC,
		OP_PCR_HI,
		OP_PCR_LO,
		OP_PIL_HI,
		OP_PIL_LO,
		OP_ST_TYPE,
		OP_EPID_HI,
		OP_EPID_LO,
		OP_ES_HI,
		OP_ES_LO
	} op_t;

	typedef struct packed {
		logic [7:0] section_byte;
		logic       section_start;
	} in_item_t;

	typedef struct packed {
		logic        entry_kind;
		logic [7:0]  tbl_id;
		logic [15:0] prog_num;
		logic [4:0]  ver_num;
		logic        current_next;
		logic [7:0]  sec_num;
		logic [7:0]  last_sec_num;
		logic [12:0] pcr_pid;
		logic [11:0] prog_info_len;
		logic [7:0]  strm_type;
		logic [12:0] es_pid;
		logic [11:0] es_desc_len;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

[hdl/pmt_front.sv]
// Byte classifier: tracks section structure and tags each useful byte.
module pmt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  pmt_pkg::in_item_t item,
	output logic              cmd_wr,
	output pmt_pkg::cmd_t     cmd
);
	import pmt_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_ENTRY,
		PH_DONE
	} phase_t;

	// header byte positions (table id is position 0)
	localparam logic [3:0] POS_LEN_HI  = 4'd1;
	localparam logic [3:0] POS_LEN_LO  = 4'd2;
	localparam logic [3:0] POS_PROG_HI = 4'd3;
	localparam logic [3:0] POS_PROG_LO = 4'd4;
	localparam logic [3:0] POS_VERSION = 4'd5;
	localparam logic [3:0] POS_SECNUM  = 4'd6;
	localparam logic [3:0] POS_LASTSEC = 4'd7;
	localparam logic [3:0] POS_PCR_HI  = 4'd8;
	localparam logic [3:0] POS_PCR_LO  = 4'd9;
	localparam logic [3:0] POS_PIL_HI  = 4'd10;
	// entry byte positions
	localparam logic [3:0] POS_ST      = 4'd0;
	localparam logic [3:0] POS_EPID_HI = 4'd1;
	localparam logic [3:0] POS_EPID_LO = 4'd2;
	localparam logic [3:0] POS_ES_HI   = 4'd3;

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [12:0] rem_q, rem_d;
	logic [11:0] skip_q, skip_d;
	logic [11:0] sec_len_q, sec_len_d;
	logic [3:0]  pil_hi_q, pil_hi_d;
	logic [3:0]  es_hi_q, es_hi_d;

	logic [7:0]  b;
	logic [11:0] pil_w;
	logic [11:0] es_w;
	logic [12:0] hdr_total;
	logic [12:0] ent_size;
	logic [12:0] rem_hdr;
	logic [12:0] rem_ent;

	assign b         = item.section_byte;
	assign pil_w     = {pil_hi_q, b};
	assign es_w      = {es_hi_q, b};
	assign hdr_total = HDR_FIXED_LEN + {1'b0, pil_w};
	assign ent_size  = ENTRY_FIXED_LEN + {1'b0, es_w};
	assign rem_hdr   = ({1'b0, sec_len_q} > hdr_total) ? ({1'b0, sec_len_q} - hdr_total) : '0;
	assign rem_ent   = (rem_q > ent_size) ? (rem_q - ent_size) : '0;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		rem_d     = rem_q;
		skip_d    = skip_q;
		sec_len_d = sec_len_q;
		pil_hi_d  = pil_hi_q;
		es_hi_d   = es_hi_q;
		cmd_wr    = 1'b0;
		cmd.op    = OP_START;
		cmd.data  = b;
		if (accept) begin
			if (item.section_start) begin
				// a start mark always opens a fresh section
				phase_d   = PH_HEADER;
				pos_d     = POS_LEN_HI;
				rem_d     = '0;
				skip_d    = '0;
				sec_len_d = '0;
				cmd_wr    = 1'b1;
				cmd.op    = OP_START;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						pos_d = pos_q + 4'd1;
						case (pos_q)
							POS_LEN_HI: sec_len_d = {b[3:0], 8'h00};
							POS_LEN_LO: sec_len_d = {sec_len_q[11:8], b};
							POS_PROG_HI: begin
								cmd_wr = 1'b1;
								cmd.op = OP_PROG_HI;
							end
							POS_PROG_LO: begin
								cmd_wr = 1'b1;
								cmd.op = OP_PROG_LO;
							end
							POS_VERSION: begin
								cmd_wr = 1'b1;
								cmd.op = OP_VERSION;
							end
							POS_SECNUM: begin
								cmd_wr = 1'b1;
								cmd.op = OP_SECNUM;
							end
							POS_LASTSEC: begin
								cmd_wr = 1'b1;
								cmd.op = OP_LASTSEC;
							end
							POS_PCR_HI: begin
								cmd_wr = 1'b1;
								cmd.op = OP_PCR_HI;
							end
							POS_PCR_LO: begin
								cmd_wr = 1'b1;
								cmd.op = OP_PCR_LO;
							end
							POS_PIL_HI: begin
								cmd_wr   = 1'b1;
								cmd.op   = OP_PIL_HI;
								pil_hi_d = b[3:0];
							end
							default: begin
								// last header byte: header result, then any descriptors, else entries
								cmd_wr = 1'b1;
								cmd.op = OP_PIL_LO;
								rem_d  = rem_hdr;
								if (pil_w != '0) begin
									skip_d  = pil_w;
									phase_d = PH_SKIP;
								end else begin
									pos_d   = POS_ST;
									phase_d = (rem_hdr != '0) ? PH_ENTRY : PH_DONE;
								end
							end
						endcase
					end
					PH_SKIP: begin
						skip_d = skip_q - 12'd1;
						if (skip_q == 12'd1) begin
							pos_d   = POS_ST;
							phase_d = (rem_q != '0) ? PH_ENTRY : PH_DONE;
						end
					end
					PH_ENTRY: begin
						pos_d  = pos_q + 4'd1;
						cmd_wr = 1'b1;
						case (pos_q)
							POS_ST:      cmd.op = OP_ST_TYPE;
							POS_EPID_HI: cmd.op = OP_EPID_HI;
							POS_EPID_LO: cmd.op = OP_EPID_LO;
							POS_ES_HI: begin
								cmd.op  = OP_ES_HI;
								es_hi_d = b[3:0];
							end
							default: begin
								cmd.op = OP_ES_LO;
								rem_d  = rem_ent;
								if (es_w != '0) begin
									skip_d  = es_w;
									phase_d = PH_SKIP;
								end else begin
									pos_d   = POS_ST;
									phase_d = (rem_ent != '0) ? PH_ENTRY : PH_DONE;
								end
							end
						endcase
					end
					default: ; // idle or done: byte dropped
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			rem_q     <= '0;
			skip_q    <= '0;
			sec_len_q <= '0;
			pil_hi_q  <= '0;
			es_hi_q   <= '0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			rem_q     <= rem_d;
			skip_q    <= skip_d;
			sec_len_q <= sec_len_d;
			pil_hi_q  <= pil_hi_d;
			es_hi_q   <= es_hi_d;
		end
	end

endmodule

[hdl/pmt_cmd_queue.sv]
// Short command queue between classifier and field assembler.
module pmt_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  pmt_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd,
	output pmt_pkg::cmd_t rd_data,
	output logic          empty
);
	import pmt_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/pmt_back.sv]
// Field assembler with result queue: builds header and entry results.
module pmt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  pmt_pkg::cmd_t      cmd,
	output logic               cmd_rd,
	input  logic               pop,
	output logic               empty,
	output pmt_pkg::out_item_t result
);
	import pmt_pkg::*;

	// held section fields
	logic [7:0]  tid_q;
	logic [15:0] prog_q;
	logic [4:0]  ver_q;
	logic        cn_q;
	logic [7:0]  sn_q;
	logic [7:0]  lsn_q;
	logic [12:0] pcr_q;
	logic [11:0] pil_q;
	logic [7:0]  st_q;
	logic [12:0] epid_q;
	logic [3:0]  es_hi_q;

	// result queue
	out_item_t         res_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic      out_pop;
	logic      room;
	logic      res_wr;
	out_item_t res_d;
	logic [7:0] b;

	assign b       = cmd.data;
	assign out_pop = pop && (cnt_q != '0);
	assign room    = (cnt_q != QCNT_W'(QDEPTH)) || out_pop;
	assign cmd_rd  = !cmd_empty && room;
	assign empty   = (cnt_q == '0);
	assign result  = res_mem_q[rptr_q];

	always_comb begin
		res_wr              = 1'b0;
		res_d.entry_kind    = 1'b0;
		res_d.tbl_id        = tid_q;
		res_d.prog_num      = prog_q;
		res_d.ver_num       = ver_q;
		res_d.current_next  = cn_q;
		res_d.sec_num       = sn_q;
		res_d.last_sec_num  = lsn_q;
		res_d.pcr_pid       = pcr_q;
		res_d.prog_info_len = pil_q;
		res_d.strm_type     = '0;
		res_d.es_pid        = '0;
		res_d.es_desc_len   = '0;
		if (cmd_rd) begin
			case (cmd.op)
				OP_PIL_LO: begin
					res_wr              = 1'b1;
					res_d.prog_info_len = {pil_q[11:8], b};
				end
				OP_ES_LO: begin
					res_wr            = 1'b1;
					res_d.entry_kind  = 1'b1;
					res_d.strm_type   = st_q;
					res_d.es_pid      = epid_q;
					res_d.es_desc_len = {es_hi_q, b};
				end
				default: ;
			endcase
		end
	end

	// field registers: every field is rewritten before any result uses it
	always_ff @(posedge clk) begin
		if (cmd_rd) begin
			case (cmd.op)
				OP_START:   tid_q          <= b;
				OP_PROG_HI: prog_q[15:8]   <= b;
				OP_PROG_LO: prog_q[7:0]    <= b;
				OP_VERSION: begin
					ver_q <= b[5:1];
					cn_q  <= b[0];
				end
				OP_SECNUM:  sn_q           <= b;
				OP_LASTSEC: lsn_q          <= b;
				OP_PCR_HI:  pcr_q[12:8]    <= b[4:0];
				OP_PCR_LO:  pcr_q[7:0]     <= b;
				OP_PIL_HI:  pil_q[11:8]    <= b[3:0];
				OP_PIL_LO:  pil_q[7:0]     <= b;
				OP_ST_TYPE: st_q           <= b;
				OP_EPID_HI: epid_q[12:8]   <= b[4:0];
				OP_EPID_LO: epid_q[7:0]    <= b;
				OP_ES_HI:   es_hi_q        <= b[3:0];
				default: ;
			endcase
		end
		if (res_wr) begin
			res_mem_q[wptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (res_wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (out_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({res_wr, out_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/pmt_section_parser.sv]
// Top level of the PMT section parser: classifier, command queue, assembler.
// Throughput: one section byte per cycle, sustained, while results are taken.
// A result passes the registered command queue, then the result queue, to the result ports.
// Rate is set by the classifier, which decides each byte's role combinationally.
// Reset (arst_n low, asynchronous): parser idle, both queues empty; bytes are
// ignored until one arrives with section_start set.
module pmt_section_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pmt_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output pmt_pkg::out_item_t result
);
	import pmt_pkg::*;

	logic accept;   // input transfer this cycle
	logic cmd_wr;   // classifier has a byte for the assembler
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_rd;
	logic cmd_empty;

	// The input side stalls only when the command queue is full; ignored
	// bytes (skipped descriptors, CRC, stray bytes) are taken and dropped.
	assign accept = push && !full;

	// Front: walks header, descriptor skips and stream entries; it owns the
	// length bookkeeping so it never waits on the assembler.
	pmt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cmd_wr (cmd_wr),
		.cmd    (cmd_in)
	);

	// Two-entry queue decouples classification from result building.
	pmt_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_wr),
		.wr_data (cmd_in),
		.full    (full),
		.rd      (cmd_rd),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// Back: collects tagged bytes into fields and queues one result on the
	// last header byte and on the last byte of each stream entry.
	pmt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_rd    (cmd_rd),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[tb/pmt_parse_check_pkg.sv]
// Result predictor and scoreboard for the PMT section parser testbench.
package pmt_parse_check_pkg;

	import pmt_pkg::*;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_HEADER,
		PS_SKIP_PI,
		PS_ENTRY,
		PS_SKIP_ES,
		PS_DONE
	} parse_state_t;

	class pmt_parse_scoreboard;

		out_item_t    expected_results[$];
		int unsigned  mismatches;
		int unsigned  headers_checked;
		int unsigned  entries_checked;
		int unsigned  bytes_noted;

		// predictor state
		parse_state_t state;
		logic [11:0]  pos;
		logic [12:0]  remaining;
		logic [11:0]  sec_len;
		logic [11:0]  skip_left;
		out_item_t    cur;

		function new();
			state = PS_IDLE;
			pos = '0;
			remaining = '0;
			sec_len = '0;
			skip_left = '0;
			cur = '0;
			mismatches = 0;
			headers_checked = 0;
			entries_checked = 0;
			bytes_noted = 0;
		endfunction

		function void emit(logic kind);
			out_item_t r;
			r = cur;
			r.entry_kind = kind;
			if (!kind) begin
				r.strm_type = '0;
				r.es_pid = '0;
				r.es_desc_len = '0;
			end
			expected_results.insert(expected_results.size(), r);
		endfunction

		function void end_of_skip();
			pos = '0;
			state = (remaining != 0) ? PS_ENTRY : PS_DONE;
		endfunction

		// Advance the parse by one accepted byte; queue a result where one is due.
		function void note_byte(in_item_t it);
			logic [7:0]  b;
			logic [11:0] p;
			int          total;
			int          size;
			b = it.section_byte;
			bytes_noted++;
			if (it.section_start) begin
				cur = '0;
				cur.tbl_id = b;
				sec_len = '0;
				remaining = '0;
				skip_left = '0;
				pos = 12'd1;
				state = PS_HEADER;
				return;
			end
			case (state)
				PS_HEADER: begin
					p = pos;
					pos = pos + 12'd1;
					case (p)
						12'd1: sec_len = {b[3:0], 8'h00};
						12'd2: sec_len[7:0] = b;
						12'd3: cur.prog_num[15:8] = b;
						12'd4: cur.prog_num[7:0] = b;
						12'd5: begin
							cur.ver_num = b[5:1];
							cur.current_next = b[0];
						end
						12'd6: cur.sec_num = b;
						12'd7: cur.last_sec_num = b;
						12'd8: cur.pcr_pid[12:8] = b[4:0];
						12'd9: cur.pcr_pid[7:0] = b;
						12'd10: cur.prog_info_len[11:8] = b[3:0];
						default: begin
							cur.prog_info_len[7:0] = b;
							total = int'(HDR_FIXED_LEN) + int'(cur.prog_info_len);
							remaining = (int'(sec_len) > total) ? 13'(int'(sec_len) - total) : '0;
							emit(1'b0);
							if (cur.prog_info_len != 0) begin
								skip_left = cur.prog_info_len;
								state = PS_SKIP_PI;
							end else begin
								end_of_skip();
							end
						end
					endcase
				end
				PS_SKIP_PI, PS_SKIP_ES: begin
					skip_left = skip_left - 12'd1;
					if (skip_left == 0)
						end_of_skip();
				end
				PS_ENTRY: begin
					p = pos;
					pos = pos + 12'd1;
					case (p)
						12'd0: begin
							cur.strm_type = b;
							cur.es_pid = '0;
							cur.es_desc_len = '0;
						end
						12'd1: cur.es_pid[12:8] = b[4:0];
						12'd2: cur.es_pid[7:0] = b;
						12'd3: cur.es_desc_len[11:8] = b[3:0];
						default: begin
							cur.es_desc_len[7:0] = b;
							size = int'(ENTRY_FIXED_LEN) + int'(cur.es_desc_len);
							remaining = (int'(remaining) > size) ?
								13'(int'(remaining) - size) : '0;
							emit(1'b1);
							if (cur.es_desc_len != 0) begin
								skip_left = cur.es_desc_len;
								state = PS_SKIP_ES;
							end else begin
								end_of_skip();
							end
						end
					endcase
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task cmp_field(string name, int unsigned idx, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s got %0h expected %0h",
					idx, name, got, want));
		endtask

		task check_result(out_item_t got);
			out_item_t   want;
			int unsigned idx;
			idx = headers_checked + entries_checked;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected", idx));
				return;
			end
			want = expected_results.pop_front();
			cmp_field("entry_kind", idx, 16'(got.entry_kind), 16'(want.entry_kind));
			cmp_field("tbl_id", idx, 16'(got.tbl_id), 16'(want.tbl_id));
			cmp_field("prog_num", idx, got.prog_num, want.prog_num);
			cmp_field("ver_num", idx, 16'(got.ver_num), 16'(want.ver_num));
			cmp_field("current_next", idx, 16'(got.current_next), 16'(want.current_next));
			cmp_field("sec_num", idx, 16'(got.sec_num), 16'(want.sec_num));
			cmp_field("last_sec_num", idx, 16'(got.last_sec_num),
				16'(want.last_sec_num));
			cmp_field("pcr_pid", idx, 16'(got.pcr_pid), 16'(want.pcr_pid));
			cmp_field("prog_info_len", idx, 16'(got.prog_info_len),
				16'(want.prog_info_len));
			cmp_field("strm_type", idx, 16'(got.strm_type), 16'(want.strm_type));
			cmp_field("es_pid", idx, 16'(got.es_pid), 16'(want.es_pid));
			cmp_field("es_desc_len", idx, 16'(got.es_desc_len),
				16'(want.es_desc_len));
			if (want.entry_kind)
				entries_checked++;
			else
				headers_checked++;
		endtask

	endclass

endpackage

[tb/tb_pmt_section_parser.sv]
// Testbench top for the PMT section parser: section stimulus, handshakes, checking.
module tb_pmt_section_parser;

	timeunit 1ns;
	timeprecision 1ps;

	import pmt_pkg::*;
	import pmt_parse_check_pkg::*;

	// traffic mixes: percent of cycles the sender idles / the receiver stalls
	localparam int SEND_IDLE[4] = '{0, 63, 0, 6};
	localparam int RECV_STALL[4] = '{0, 0, 63, 6};
	localparam int MIX_BYTES = 320;
	// long receiver hold, in receiver cycles after reset
	localparam int HOLD_FROM = 150;
	localparam int HOLD_CYCLES = 300;
	// no transfer at all for this many cycles means the block is stuck
	localparam int STUCK_LIMIT = 3000;
	// cycles to wait after the last expected result before calling the run done
	localparam int DRAIN_CYCLES = 8;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	int        send_idle_pct;
	int        recv_stall_pct;
	int        counted;
	in_item_t  byte_q[$];
	in_item_t  sec_q[$];

	pmt_parse_scoreboard sb;

	pmt_section_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Descriptor loop lengths: mostly empty or short, now and then a few hundred.
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(6, 1);
		if (r < 98)
			return $urandom_range(40, 7);
		return $urandom_range(600, 41);
	endfunction

	function automatic void put_byte(logic [7:0] b, logic s);
		sec_q.insert(sec_q.size(), in_item_t'({b, s}));
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom);
	endfunction

	// Build one section into sec_q. len_mode: 0 exact length, 1 a few bytes short
	// (last entry runs past the count), 2 random length, 3 the largest length.
	// es_fixed < 0 picks each entry's descriptor length at random.
	function automatic void build_section(input int pil, input int nent,
			input int es_fixed, input int len_mode);
		int          es_tab[4];
		int          body;
		int          sl;
		logic [11:0] sl12;
		logic [11:0] pil12;
		logic [11:0] es12;
		body = 0;
		for (int i = 0; i < nent; i++) begin
			es_tab[i] = (es_fixed >= 0) ? es_fixed : pick_len();
			body += int'(ENTRY_FIXED_LEN) + es_tab[i];
		end
		sl = int'(HDR_FIXED_LEN) + pil + body;
		case (len_mode)
			1: sl -= $urandom_range(3, 1);
			2: sl = $urandom_range(4095);
			3: sl = 4095;
			default: ;
		endcase
		if (sl > 4095)
			sl = 4095;
		if (sl < 0)
			sl = 0;
		sl12 = 12'(sl);
		pil12 = 12'(pil);
		sec_q.delete();
		put_byte($urandom_range(1) ? 8'h02 : rnd8(), 1'b1);
		// reserved and indicator bits above the length nibbles stay random
		put_byte({4'($urandom), sl12[11:8]}, 1'b0);
		put_byte(sl12[7:0], 1'b0);
		for (int i = 0; i < 7; i++)
			put_byte(rnd8(), 1'b0);
		put_byte({4'($urandom), pil12[11:8]}, 1'b0);
		put_byte(pil12[7:0], 1'b0);
		for (int i = 0; i < pil; i++)
			put_byte(rnd8(), 1'b0);
		for (int e = 0; e < nent; e++) begin
			es12 = 12'(es_tab[e]);
			for (int i = 0; i < 3; i++)
				put_byte(rnd8(), 1'b0);
			put_byte({4'($urandom), es12[11:8]}, 1'b0);
			put_byte(es12[7:0], 1'b0);
			for (int i = 0; i < es_tab[e]; i++)
				put_byte(rnd8(), 1'b0);
		end
		// CRC bytes, never checked by the block
		for (int i = 0; i < 4; i++)
			put_byte(rnd8(), 1'b0);
	endfunction

	// Mostly well-formed sections; the rest are cut short, restarted midway,
	// given a bogus length, or preceded by stray bytes with no start mark.
	function automatic void add_random_section();
		int r;
		int m;
		int at;
		r = $urandom_range(99);
		build_section(pick_len(), $urandom_range(4), -1,
			(r < 65) ? 0 : (r < 75) ? 1 : (r < 82) ? 2 : 0);
		m = $urandom_range(99);
		if (m >= 82 && m < 92) begin
			at = $urandom_range(sec_q.size() - 1, 1);
			while (sec_q.size() > at)
				void'(sec_q.pop_back());
		end else if (m >= 92 && m < 97) begin
			at = $urandom_range(sec_q.size() - 1, 1);
			sec_q[at].section_start = 1'b1;
		end else if (m >= 97) begin
			// stray bytes are not counted toward the stimulus budget
			repeat ($urandom_range(6, 1))
				byte_q.insert(byte_q.size(), in_item_t'({rnd8(), 1'b0}));
		end
		counted += sec_q.size();
		foreach (sec_q[i])
			byte_q.insert(byte_q.size(), sec_q[i]);
	endfunction

	// One byte transfer, with random sender idle cycles ahead of it.
	task automatic send_byte(input in_item_t it);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			item = {rnd8(), 1'($urandom)};
			@(negedge clk);
		end
		push = 1'b1;
		item = it;
		do
			@(posedge clk);
		while (full);
		sb.note_byte(it);
	endtask

	task automatic send_all();
		while (byte_q.size() != 0)
			send_byte(byte_q.pop_front());
	endtask

	// Result side: random stalls per the current mix, plus one long hold that
	// lets the block fill up and push back on the sender.
	initial begin : result_side
		int cyc;
		cyc = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_CYCLES)
				pop = 1'b0;
			else
				pop = ($urandom_range(99) >= recv_stall_pct);
			cyc++;
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(result);
		end
	end

	// Stuck detector: any transfer on either side resets the count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STUCK_LIMIT) begin
				$display("stuck: no transfer for %0d cycles", quiet);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int ph;
		int target;
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		counted = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a stray byte before any section, a zero section abandoned by a
		// new start mark, then an all-ones header whose single entry exactly uses
		// up the remaining count, and a trailing byte that must be ignored.
		byte_q.insert(byte_q.size(), in_item_t'({8'hA5, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'h00, 1'b1}));
		repeat (5) byte_q.insert(byte_q.size(), in_item_t'({8'h00, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'hFF, 1'b1}));
		byte_q.insert(byte_q.size(), in_item_t'({8'hF0, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'h12, 1'b0}));
		repeat (7) byte_q.insert(byte_q.size(), in_item_t'({8'hFF, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'hF0, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'h00, 1'b0}));
		repeat (3) byte_q.insert(byte_q.size(), in_item_t'({8'hFF, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'hF0, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'h00, 1'b0}));
		byte_q.insert(byte_q.size(), in_item_t'({8'h3C, 1'b0}));
		send_all();

		// Random sections across the four traffic mixes.
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			target = counted + MIX_BYTES;
			while (counted < target) begin
				add_random_section();
				send_all();
			end
		end

		// Longer descriptor loops: 300 bytes of program info under the largest
		// section length, then one entry with 200 bytes of ES info that runs
		// past the count.
		build_section(300, 0, -1, 3);
		foreach (sec_q[i])
			byte_q.insert(byte_q.size(), sec_q[i]);
		build_section(0, 1, 200, 1);
		foreach (sec_q[i])
			byte_q.insert(byte_q.size(), sec_q[i]);
		send_all();

		@(negedge clk);
		push = 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d section bytes over four traffic mixes and a long result hold.",
			sb.bytes_noted);
		$display("Checked %0d header results and %0d stream entry results.",
			sb.headers_checked, sb.entries_checked);
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
hdl/pmt_pkg.sv
hdl/pmt_front.sv
hdl/pmt_cmd_queue.sv
hdl/pmt_back.sv
hdl/pmt_section_parser.sv
tb/pmt_parse_check_pkg.sv
tb/tb_pmt_section_parser.sv
